>>> hdl/pidtf_pkg.sv
// Shared constants and types for the three-form PID controller.
package pidtf_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH = 3'd7;

    // Controller forms.
    localparam logic [1:0] MODE_PID   = 2'd0;
    localparam logic [1:0] MODE_D_FB  = 2'd1;
    localparam logic [1:0] MODE_PD_FB = 2'd2;

    // Reset values of the limit registers.
    localparam logic signed [15:0] INTEG_LOW_RST  = 16'sd1000;
    localparam logic signed [15:0] INTEG_HIGH_RST = 16'sd2000;
    localparam logic signed [15:0] DRIVE_LOW_RST  = 16'sd1000;
    localparam logic signed [15:0] DRIVE_HIGH_RST = 16'sd1000;

    // Data widths.
    localparam int SAMPLE_W = 16;
    localparam int OPER_W   = 18;
    localparam int TERM_W   = 24;
    localparam int SHIFT_W  = 26;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 80;

    // Bit positions of the integrator value in the output word.
    localparam int OUT_ITERM_LSB = 40;
    localparam int OUT_ITERM_MSB = 55;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [TERM_W-1:0]   t_term;

endpackage

>>> hdl/pidtf_term.sv
// Gain times operand, floor shift by 8 and saturation to 24 bits.
module pidtf_term (
    input  pidtf_pkg::t_sample             i_gain,
    input  logic signed [pidtf_pkg::OPER_W-1:0] i_operand,
    output pidtf_pkg::t_term               o_term
);

    localparam logic signed [pidtf_pkg::SHIFT_W-1:0] SAT_MAX = 26'sd8388607;
    localparam logic signed [pidtf_pkg::SHIFT_W-1:0] SAT_MIN = -26'sd8388608;

    logic signed [pidtf_pkg::SAMPLE_W+pidtf_pkg::OPER_W-1:0] w_prod;
    logic signed [pidtf_pkg::SHIFT_W-1:0]                    w_shift;

    always_comb begin
        w_prod = i_gain * i_operand;
        // Dropping the low bits of a two's complement value rounds toward minus infinity.
        w_shift = w_prod[pidtf_pkg::SAMPLE_W+pidtf_pkg::OPER_W-1:8];
        if (w_shift > SAT_MAX) begin
            o_term = SAT_MAX[pidtf_pkg::TERM_W-1:0];
        end else if (w_shift < SAT_MIN) begin
            o_term = SAT_MIN[pidtf_pkg::TERM_W-1:0];
        end else begin
            o_term = w_shift[pidtf_pkg::TERM_W-1:0];
        end
    end

endmodule

>>> hdl/pid_controller_three_forms.sv
// One word per cycle while the output side is not stalled; the integrator and history
// are written together with the output register.
// An input register and an output register, both under one stall, part the two sides.
// Reset (synchronous, active low) empties both stages, clears the integrator and
// history, and loads the gains with zero and the limits with their defaults.
module pid_controller_three_forms (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // setpoint[15:0], measured[31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // drive[15:0], p_term[39:16], i_term[55:40], d_term[79:56]
);

    logic [1:0]         r_mode;
    pidtf_pkg::t_sample r_gain_p, r_gain_i, r_gain_d;
    pidtf_pkg::t_sample r_integ_low, r_integ_high, r_drive_low, r_drive_high;

    logic               r_s1_vld;
    pidtf_pkg::t_sample r_sp, r_fb;

    pidtf_pkg::t_sample          r_integ;
    logic signed [16:0]          r_last_err;
    pidtf_pkg::t_sample          r_last_fb;

    logic                        r_out_vld;
    logic [pidtf_pkg::OUT_W-1:0] r_out;

    logic                                  w_adv;
    logic                                  w_p_on_fb, w_d_on_fb;
    logic signed [16:0]                    w_err;
    logic signed [pidtf_pkg::OPER_W-1:0]   w_p_op, w_i_op, w_d_op;
    pidtf_pkg::t_term                      w_p, w_i, w_d;
    logic signed [pidtf_pkg::SHIFT_W-1:0]  w_acc, w_acc_hi, w_ctl;
    pidtf_pkg::t_sample                    n_integ, n_drive;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pidtf_pkg::MODE_PID;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_integ_low  <= pidtf_pkg::INTEG_LOW_RST;
            r_integ_high <= pidtf_pkg::INTEG_HIGH_RST;
            r_drive_low  <= pidtf_pkg::DRIVE_LOW_RST;
            r_drive_high <= pidtf_pkg::DRIVE_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidtf_pkg::REG_MODE:       r_mode       <= i_cfg_data[1:0];
                pidtf_pkg::REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                pidtf_pkg::REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                pidtf_pkg::REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                pidtf_pkg::REG_INTEG_LOW:  r_integ_low  <= i_cfg_data;
                pidtf_pkg::REG_INTEG_HIGH: r_integ_high <= i_cfg_data;
                pidtf_pkg::REG_DRIVE_LOW:  r_drive_low  <= i_cfg_data;
                pidtf_pkg::REG_DRIVE_HIGH: r_drive_high <= i_cfg_data;
            endcase
        end
    end

    assign w_adv      = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_sp <= i_s_tdata[15:0];
            r_fb <= i_s_tdata[31:16];
        end
    end

    // The unused mode code takes the same path as proportional and derivative on feedback.
    assign w_p_on_fb = (r_mode != pidtf_pkg::MODE_PID) && (r_mode != pidtf_pkg::MODE_D_FB);
    assign w_d_on_fb = (r_mode != pidtf_pkg::MODE_PID);

    always_comb begin
        w_err  = 17'(r_sp) - 17'(r_fb);
        w_i_op = 18'(w_err);
        w_p_op = w_p_on_fb ? (18'sd0 - 18'(r_fb)) : 18'(w_err);
        w_d_op = w_d_on_fb ? (18'(r_last_fb) - 18'(r_fb)) : (18'(w_err) - 18'(r_last_err));
    end

    pidtf_term u_term_p (.i_gain(r_gain_p), .i_operand(w_p_op), .o_term(w_p));
    // Saturating the integral step does not change the clamped sum: any value past
    // 24 bits already lands beyond both 16-bit clamps.
    pidtf_term u_term_i (.i_gain(r_gain_i), .i_operand(w_i_op), .o_term(w_i));
    pidtf_term u_term_d (.i_gain(r_gain_d), .i_operand(w_d_op), .o_term(w_d));

    always_comb begin
        w_acc    = 26'(r_integ) + 26'(w_i);
        w_acc_hi = (w_acc > 26'(r_integ_high)) ? 26'(r_integ_high) : w_acc;
        n_integ  = (w_acc_hi < 26'(r_integ_low)) ? r_integ_low : w_acc_hi[15:0];
        w_ctl    = 26'(w_p) + 26'(n_integ) + 26'(w_d);
        if (w_ctl > 26'(r_drive_high)) begin
            n_drive = r_drive_high;
        end else if (w_ctl < 26'(r_drive_low)) begin
            n_drive = r_drive_low;
        end else begin
            n_drive = w_ctl[15:0];
        end
    end

    // Controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_integ    <= '0;
            r_last_err <= '0;
            r_last_fb  <= '0;
        end else if (w_adv) begin
            r_out_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_integ    <= n_integ;
                r_last_err <= w_err;
                r_last_fb  <= r_fb;
            end
        end
        if (w_adv && r_s1_vld) begin
            r_out <= {w_d, n_integ, w_p, n_drive};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

>>> hdl/pidtf_checker.sv
// Port-level checks for the PID controller, attached by bind.
module pidtf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [15:0] i_cfg_data,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata
);

    logic signed [15:0] r_integ_low;
    logic signed [15:0] w_iterm;

    // Shadow of the lower integrator clamp.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_low <= pidtf_pkg::INTEG_LOW_RST;
        end else if (i_cfg_we && (i_cfg_idx == pidtf_pkg::REG_INTEG_LOW)) begin
            r_integ_low <= i_cfg_data;
        end
    end

    assign w_iterm = o_m_tdata[pidtf_pkg::OUT_ITERM_MSB:pidtf_pkg::OUT_ITERM_LSB];

    // The input side never stalls while the output register is empty.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output register");

    // A word accepted into an empty pipeline appears after passing the input and output registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> ##1 o_m_tvalid)
        else $error("result word missing two cycles after input");

    // The lower clamp always wins, so the integrator never reads below it.
    a_iterm_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_iterm >= r_integ_low))
        else $error("integrator value below its lower clamp");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

endmodule

bind pid_controller_three_forms pidtf_checker u_pidtf_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for the three-form PID controller with a clamped integrator.
`timescale 1ns / 100ps

module testbench;

    // The fourth mode code has no name in the package; it acts like MODE_PD_FB.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        pidtf_pkg::t_sample setpoint;
        pidtf_pkg::t_sample measured;
    } t_sample_pair;

    typedef struct packed {
        pidtf_pkg::t_sample drive;
        pidtf_pkg::t_term   p_term;
        pidtf_pkg::t_sample i_term;
        pidtf_pkg::t_term   d_term;
    } t_pid_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // setpoint[15:0], measured[31:16]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;        // drive[15:0], p_term[39:16], i_term[55:40], d_term[79:56]

    pid_controller_three_forms dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Controller copy: configuration and state as the block should hold them.
    logic [1:0] m_mode = pidtf_pkg::MODE_PID;
    longint m_kp = 0;
    longint m_ki = 0;
    longint m_kd = 0;
    longint m_ilo = pidtf_pkg::INTEG_LOW_RST;
    longint m_ihi = pidtf_pkg::INTEG_HIGH_RST;
    longint m_dlo = pidtf_pkg::DRIVE_LOW_RST;
    longint m_dhi = pidtf_pkg::DRIVE_HIGH_RST;
    longint m_integ = 0;
    longint m_last_err = 0;
    longint m_last_meas = 0;

    t_sample_pair sample_queue[$];
    t_pid_out     expected_outs[$];
    t_sample_pair cur_pair;
    int mismatches = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap = 0;
    int snk_stall = 0;
    int sp_level = 0;

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // One control step; updates the integrator and the history.
    function automatic t_pid_out pid_predict(pidtf_pkg::t_sample sp, pidtf_pkg::t_sample fb);
        longint err, p, acc, d, ctl;
        t_pid_out r;
        err = longint'(sp) - longint'(fb);
        if (m_mode == pidtf_pkg::MODE_PD_FB || m_mode == MODE_SPARE)
            p = sat24((m_kp * (-longint'(fb))) >>> 8);
        else
            p = sat24((m_kp * err) >>> 8);
        acc = m_integ + ((m_ki * err) >>> 8);
        // Upper clamp first, so the lower one wins when the two cross.
        if (acc > m_ihi) acc = m_ihi;
        if (acc < m_ilo) acc = m_ilo;
        m_integ = acc;
        if (m_mode != pidtf_pkg::MODE_PID)
            d = sat24((m_kd * (-(longint'(fb) - m_last_meas))) >>> 8);
        else
            d = sat24((m_kd * (err - m_last_err)) >>> 8);
        ctl = p + acc + d;
        if (ctl > m_dhi) r.drive = pidtf_pkg::t_sample'(m_dhi);
        else if (ctl < m_dlo) r.drive = pidtf_pkg::t_sample'(m_dlo);
        else r.drive = pidtf_pkg::t_sample'(ctl);
        r.p_term = pidtf_pkg::t_term'(p);
        r.i_term = pidtf_pkg::t_sample'(acc);
        r.d_term = pidtf_pkg::t_term'(d);
        m_last_err = err;
        m_last_meas = fb;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Input side: presents queued words and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_outs.push_back(pid_predict(cur_pair.setpoint, cur_pair.measured));
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(0, 14);
                    i_s_tvalid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    cur_pair = sample_queue.pop_front();
                    i_s_tdata <= {cur_pair.measured, cur_pair.setpoint};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each accepted word and stalls in bursts.
    always @(posedge i_clk) begin
        t_pid_out got, want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.drive  = o_m_tdata[15:0];
                got.p_term = o_m_tdata[39:16];
                got.i_term = o_m_tdata[pidtf_pkg::OUT_ITERM_MSB:pidtf_pkg::OUT_ITERM_LSB];
                got.d_term = o_m_tdata[79:56];
                if (expected_outs.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, got %h", $time, o_m_tdata);
                end else begin
                    want = expected_outs.pop_front();
                    check_field("drive", want.drive, got.drive);
                    check_field("p_term", want.p_term, got.p_term);
                    check_field("i_term", want.i_term, got.i_term);
                    check_field("d_term", want.d_term, got.d_term);
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < snk_idle_pct) begin
                snk_stall = $urandom_range(0, 14);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            pidtf_pkg::REG_MODE:       m_mode = val[1:0];
            pidtf_pkg::REG_GAIN_P:     m_kp = longint'($signed(val));
            pidtf_pkg::REG_GAIN_I:     m_ki = longint'($signed(val));
            pidtf_pkg::REG_GAIN_D:     m_kd = longint'($signed(val));
            pidtf_pkg::REG_INTEG_LOW:  m_ilo = longint'($signed(val));
            pidtf_pkg::REG_INTEG_HIGH: m_ihi = longint'($signed(val));
            pidtf_pkg::REG_DRIVE_LOW:  m_dlo = longint'($signed(val));
            default:                   m_dhi = longint'($signed(val));
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [1:0] mode, int kp, int ki, int kd,
                             int ilo, int ihi, int dlo, int dhi);
        logic [13:0] junk;
        junk = $urandom;
        // Only the low two bits of the mode register count.
        write_reg(pidtf_pkg::REG_MODE, {junk, mode});
        write_reg(pidtf_pkg::REG_GAIN_P, 16'(kp));
        write_reg(pidtf_pkg::REG_GAIN_I, 16'(ki));
        write_reg(pidtf_pkg::REG_GAIN_D, 16'(kd));
        write_reg(pidtf_pkg::REG_INTEG_LOW, 16'(ilo));
        write_reg(pidtf_pkg::REG_INTEG_HIGH, 16'(ihi));
        write_reg(pidtf_pkg::REG_DRIVE_LOW, 16'(dlo));
        write_reg(pidtf_pkg::REG_DRIVE_HIGH, 16'(dhi));
    endtask

    task automatic queue_pair(int sp, int fb);
        t_sample_pair s;
        s.setpoint = pidtf_pkg::t_sample'(sp);
        s.measured = pidtf_pkg::t_sample'(fb);
        sample_queue.push_back(s);
    endtask

    // Waits until every queued word went in and every result came out.
    task automatic drain();
        while (sample_queue.size() != 0 || i_s_tvalid || expected_outs.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    default: return -1;
                endcase
            end
            1, 2, 3: return int'($urandom_range(0, 2000)) - 1000;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 3))
            0: return int'($signed(16'($urandom)));
            1: begin
                case ($urandom_range(0, 2))
                    0: return -32768;
                    1: return 32767;
                    default: return 0;
                endcase
            end
            default: return int'($urandom_range(0, 1024)) - 512;
        endcase
    endfunction

    task automatic pick_bounds(output int lo, output int hi);
        case ($urandom_range(0, 5))
            0: begin
                // Crossed limits.
                lo = $urandom_range(0, 5000);
                hi = -int'($urandom_range(0, 5000));
            end
            1: begin
                lo = -32768;
                hi = 32767;
            end
            default: begin
                lo = -int'($urandom_range(0, 20000));
                hi = $urandom_range(0, 20000);
            end
        endcase
    endtask

    // Mostly a held setpoint with feedback close to it, now and then a step;
    // the rest are unrelated samples.
    task automatic queue_items(int n);
        int sp, fb;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0)
                sp_level = pick_sample();
            if ($urandom_range(0, 9) < 7) begin
                sp = sp_level;
                fb = sp_level + int'($urandom_range(0, 400)) - 200;
                if (fb > 32767) fb = 32767;
                if (fb < -32768) fb = -32768;
            end else begin
                sp = pick_sample();
                fb = pick_sample();
            end
            queue_pair(sp, fb);
        end
    endtask

    initial begin
        int ilo, ihi, dlo, dhi;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 20;
        snk_idle_pct = 20;

        // Reset defaults: zero gains pin the integrator at 1000, drive stays at 1000.
        queue_pair(0, 0);
        queue_pair(32767, -32768);
        drain();

        write_all(pidtf_pkg::MODE_PID, 256, 128, -256, -32768, 32767, -32768, 32767);
        queue_pair(32767, -32768);
        queue_pair(-32768, 32767);
        queue_pair(1, 2);
        queue_pair(-1, 0);
        queue_pair(0, 0);
        drain();

        // Extreme gains on the largest errors saturate the 24-bit derivative term.
        write_all(pidtf_pkg::MODE_PID, -32768, 32767, 32767, -32768, 32767, -32768, 32767);
        queue_pair(32767, -32768);
        queue_pair(-32768, 32767);
        queue_pair(-32768, 32767);
        drain();

        write_all(pidtf_pkg::MODE_D_FB, 300, -5, 400, -2000, 2000, -3000, 3000);
        queue_pair(1000, 900);
        queue_pair(1000, -32768);
        queue_pair(0, 32767);
        drain();

        write_all(pidtf_pkg::MODE_PD_FB, -700, 90, -32768, -32768, 32767, -32768, 32767);
        queue_pair(-500, 32767);
        queue_pair(200, -32768);
        drain();

        write_all(MODE_SPARE, 32767, -300, 1000, -100, 100, -32768, 32767);
        queue_pair(100, -200);
        queue_pair(-32768, 32767);
        drain();

        // Crossed integrator clamps and crossed drive limits.
        write_all(pidtf_pkg::MODE_PID, 100, 50, 20, 500, -500, 100, -100);
        queue_pair(3000, 1000);
        queue_pair(-3000, 1000);
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            if (ph >= 12) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 15;
                    default: src_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: snk_idle_pct = 0;
                    1: snk_idle_pct = 15;
                    default: snk_idle_pct = 40;
                endcase
            end
            pick_bounds(ilo, ihi);
            pick_bounds(dlo, dhi);
            write_all(2'($urandom_range(0, 3)), pick_gain(), pick_gain(), pick_gain(),
                      ilo, ihi, dlo, dhi);
            queue_items(130);
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
